/* sv/btc_pkg.sv */
// ----------------------------------------------------------------------------
// Bitmap text console package
// Shared types and constants for the text console: register map, operation
// codes, command kinds, special characters and the configuration bundle.
// ----------------------------------------------------------------------------
package btc_pkg;

  // Register map (index of each register, byte address is 4 times this).
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FORE   = 2'd2;
  localparam logic [1:0] REG_BACK   = 2'd3;

  // Input operations.
  localparam logic [1:0] OP_PRINT = 2'd0;
  localparam logic [1:0] OP_FONT  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Output command kinds.
  localparam logic KIND_DRAW  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Character handling.
  localparam logic [7:0] CHAR_LF       = 8'd10;
  localparam logic [7:0] CHAR_CR       = 8'd13;
  localparam logic [7:0] CHAR_FIRST    = 8'd32;
  localparam logic [7:0] CHAR_LAST     = 8'd126;
  localparam logic [7:0] CHAR_SUBST    = 8'h3F;

  // Screen geometry used when either resolution register is zero.
  localparam logic [8:0] DEFAULT_COLS  = 9'd80;
  localparam logic [8:0] DEFAULT_LINES = 9'd25;

  // Glyph store: 256 glyphs, up to 16 writable rows each.
  localparam int GLYPH_CODES = 256;
  localparam int STORE_ROWS  = 16;
  localparam int STORE_DEPTH = GLYPH_CODES * STORE_ROWS;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int ROW_AW      = $clog2(STORE_ROWS);

  // Configuration registers as seen by the console core.
  typedef struct packed {
    logic [11:0] width;
    logic [11:0] height;
    logic [23:0] fore;
    logic [23:0] back;
  } btc_cfg_t;

endpackage

/* sv/btc_regs.sv */
// ----------------------------------------------------------------------------
// Bitmap text console register file
// APB-style register port holding resolution and color registers.
// ----------------------------------------------------------------------------
module btc_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output btc_pkg::btc_cfg_t cfg
);
  import btc_pkg::*;

  logic [1:0] reg_sel;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes; the access phase commits the word.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= 12'd0;
      cfg.height <= 12'd0;
      cfg.fore   <= 24'hFFFFFF;
      cfg.back   <= 24'd0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_WIDTH:  cfg.width  <= pwdata[11:0];
        REG_HEIGHT: cfg.height <= pwdata[11:0];
        REG_FORE:   cfg.fore   <= pwdata[23:0];
        REG_BACK:   cfg.back   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register.
  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:  prdata = {20'd0, cfg.width};
      REG_HEIGHT: prdata = {20'd0, cfg.height};
      REG_FORE:   prdata = {8'd0, cfg.fore};
      REG_BACK:   prdata = {8'd0, cfg.back};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

/* sv/bitmap_text_console.sv */
// ----------------------------------------------------------------------------
// Bitmap text console
// Text console with an 8-pixel-wide bitmap font held in a synchronous glyph
// memory. Printed characters become one glyph-row command per font row.
//
//   Channel  Direction  Handshake           Contents
//   s_*      in         s_tvalid/s_tready   op, char code, font row write
//   m_*      out        m_tvalid/m_tready   draw-row or clear command
//   p*       in/out     psel/penable        resolution and color registers
//
// A printed character first reads the top font row, then sends one command
// per cycle while the output can take it, as the glyph memory streams rows.
// A wrap that fills the screen adds a clear command after the last row.
// Font writes, carriage returns and unknown ops are handled without leaving idle.
// Reset is synchronous and homes the cursor; the font is undefined until
// written. A stalled output holds the sequencer, the memory read is only
// advanced when a word leaves, so no row is dropped or repeated.
// ----------------------------------------------------------------------------
module bitmap_text_console #(
  parameter int GLYPH_HEIGHT = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Input words.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // char_code[7:0], font_row_index[11:8],
                                // font_row_bits[19:12], zero pad
  input  logic [1:0]  s_tuser,  // op[1:0]
  // Output words.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,  // pixel_x[11:0], pixel_y[23:12],
                                // row_pixels[31:24], fore_color[55:32],
                                // back_color[79:56]
  output logic        m_tuser,  // command_kind[0]
  output logic        m_tlast,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import btc_pkg::*;

  localparam int            RW       = $clog2(GLYPH_HEIGHT);
  localparam logic [RW-1:0] ROW_LAST = RW'(GLYPH_HEIGHT - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAW  = 2'd1;
  localparam logic [1:0] ST_NEWLN = 2'd2;
  localparam logic [1:0] ST_CLR   = 2'd3;

  btc_cfg_t cfg;

  logic [1:0]    state, state_next;
  logic [8:0]    cursor_col, cursor_col_next;
  logic [8:0]    cursor_line, cursor_line_next;
  logic [RW-1:0] row, row_next;
  logic [7:0]    glyph, glyph_next;

  logic [7:0]    glyph_mem [0:STORE_DEPTH-1];
  logic [7:0]    rdata;
  logic          rd_en;
  logic [STORE_AW-1:0] rd_addr;
  logic          wr_en;

  logic [1:0]    in_op;
  logic [7:0]    in_code;
  logic [3:0]    in_rix;
  logic [7:0]    in_bits;
  logic [7:0]    code_map;
  logic          accept;

  logic [8:0]    col_inc, line_inc;
  logic          dflt;
  logic          wrap, full;
  logic          wrap_r, full_r;
  logic [15:0]   span;
  logic [20:0]   base_full;
  logic [11:0]   base_y;

  logic          out_free, emit;
  logic          e_kind, e_last;
  logic [11:0]   e_x, e_y;
  logic [7:0]    e_bits;
  logic [23:0]   e_fore;

  btc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Unpack the input word.
  assign in_op   = s_tuser;
  assign in_code = s_tdata[7:0];
  assign in_rix  = s_tdata[11:8];
  assign in_bits = s_tdata[19:12];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Unprintable bytes are drawn with the substitute glyph.
  assign code_map = (in_code < CHAR_FIRST || in_code > CHAR_LAST) ? CHAR_SUBST : in_code;

  // Cursor advance and screen-full checks. Lines = height / GLYPH_HEIGHT,
  // so a line index n is off screen when (n + 1) * GLYPH_HEIGHT > height.
  assign col_inc  = cursor_col + 9'd1;
  assign line_inc = cursor_line + 9'd1;
  assign dflt     = (cfg.width == 12'd0) || (cfg.height == 12'd0);
  assign span     = 16'((17'(line_inc) + 17'd1) * 17'(GLYPH_HEIGHT));
  assign wrap     = dflt ? (col_inc >= DEFAULT_COLS) : (col_inc >= cfg.width[11:3]);
  assign full     = dflt ? (line_inc >= DEFAULT_LINES) : (span > {4'd0, cfg.height});
  assign base_full = 21'(cursor_line) * 21'(GLYPH_HEIGHT);

  // The cursor only moves when the sequencer returns to idle, so these
  // registered flags are current for every item by its first busy cycle.
  always_ff @(posedge clk) begin
    wrap_r <= wrap;
    full_r <= full;
    base_y <= base_full[11:0];
  end

  // Glyph memory: one write port for font loads, one registered read port.
  assign wr_en   = accept && (in_op == OP_FONT) && (int'(in_rix) < GLYPH_HEIGHT);
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {code_map, ROW_AW'(0)};
    if (accept && in_op == OP_PRINT) begin
      rd_en = 1'b1;
    end else if (state == ST_DRAW && emit) begin
      rd_en   = 1'b1;
      rd_addr = {glyph, ROW_AW'(row + RW'(1))};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      glyph_mem[{in_code, in_rix}] <= in_bits;
    end
    if (rd_en) begin
      rdata <= glyph_mem[rd_addr];
    end
  end

  // Result selection for the current cycle.
  assign out_free = !m_tvalid || m_tready;
  assign emit = out_free && ((state == ST_DRAW) || (state == ST_CLR) ||
                             (state == ST_NEWLN && full_r));

  always_comb begin
    if (state == ST_DRAW) begin
      e_kind = KIND_DRAW;
      e_x    = {cursor_col, 3'b000};
      e_y    = base_y + 12'(row);
      e_bits = (int'(row) < STORE_ROWS) ? rdata : 8'd0;
      e_fore = cfg.fore;
      e_last = (row == ROW_LAST) && !(wrap_r && full_r);
    end else begin
      e_kind = KIND_CLEAR;
      e_x    = 12'd0;
      e_y    = 12'd0;
      e_bits = 8'd0;
      e_fore = 24'd0;
      e_last = 1'b1;
    end
  end

  // Sequencer and cursor update.
  always_comb begin
    state_next       = state;
    cursor_col_next  = cursor_col;
    cursor_line_next = cursor_line;
    row_next         = row;
    glyph_next       = glyph;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (in_op == OP_PRINT) begin
            if (in_code == CHAR_LF) begin
              state_next = ST_NEWLN;
            end else if (in_code == CHAR_CR) begin
              cursor_col_next = 9'd0;
            end else begin
              state_next = ST_DRAW;
              row_next   = '0;
              glyph_next = code_map;
            end
          end else if (in_op == OP_CLEAR) begin
            state_next = ST_CLR;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_DRAW: begin
        if (emit) begin
          if (row == ROW_LAST) begin
            if (!wrap_r) begin
              cursor_col_next = col_inc;
              state_next      = ST_IDLE;
            end else if (!full_r) begin
              cursor_col_next  = 9'd0;
              cursor_line_next = line_inc;
              state_next       = ST_IDLE;
            end else begin
              state_next = ST_CLR;
            end
          end else begin
            row_next = row + RW'(1);
          end
        end
      end
      ST_NEWLN: begin
        if (!full_r) begin
          cursor_col_next  = 9'd0;
          cursor_line_next = line_inc;
          state_next       = ST_IDLE;
        end else if (emit) begin
          cursor_col_next  = 9'd0;
          cursor_line_next = 9'd0;
          state_next       = ST_IDLE;
        end
      end
      ST_CLR: begin
        if (emit) begin
          cursor_col_next  = 9'd0;
          cursor_line_next = 9'd0;
          state_next       = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cursor_col  <= 9'd0;
      cursor_line <= 9'd0;
      row         <= '0;
    end else begin
      state       <= state_next;
      cursor_col  <= cursor_col_next;
      cursor_line <= cursor_line_next;
      row         <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    glyph <= glyph_next;
  end

  // Output register: loaded when a result is produced, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {cfg.back, e_fore, e_bits, e_y, e_x};
      m_tuser <= e_kind;
      m_tlast <= e_last;
    end
  end

  // A clear command is always the final word of its item.
  a_clear_last: assert property (@(posedge clk) disable iff (rst)
    (emit && state != ST_DRAW) |=> (m_tvalid && m_tlast && m_tuser == KIND_CLEAR))
    else $error("clear command emitted without last");

  // The cursor holds still while a glyph is being drawn.
  a_cursor_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAW && $past(state) == ST_DRAW) |->
      ($stable(cursor_col) && $stable(cursor_line)))
    else $error("cursor moved during a glyph draw");

  // Every glyph starts at its top row.
  a_draw_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAW && $past(state) != ST_DRAW) |-> (row == '0))
    else $error("glyph draw did not start at row zero");

endmodule

/* tb/sv/bitmap_text_console_test.sv */
// ----------------------------------------------------------------------------
// Bitmap text console testbench
// Drives the console with font loads, printed characters, line controls and
// screen clears over a range of resolutions and colors. A built-in console
// predictor tracks the cursor, the font and the registers. Every command word
// the block emits is compared field by field against the predicted queue.
// Both stream sides idle at random, and the output side holds off once for a
// long stretch so that the input side backs up.
// ----------------------------------------------------------------------------
module bitmap_text_console_test;
  timeunit 1ns;
  timeprecision 1ps;

  import btc_pkg::*;

  localparam int GLYPH_ROWS       = 16;
  localparam int RESET_CYCLES     = 12;
  localparam int SETTLE_CYCLES    = 40;
  localparam int HOLD_CYCLES      = 400;
  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int MAX_REPORTS      = 40;
  localparam int PHASES           = 8;
  localparam int WORDS_PER_PHASE  = 28;

  // Op 3 is not decoded by the block and must be ignored.
  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam logic [23:0] RESET_BACK = 24'h000000;
  localparam logic [7:0]  CHAR_A     = 8'h41;

  // Resolutions per phase: default screen, largest screen, one column of two
  // lines, zero columns, zero lines, a 3x3 screen, a zero width and a zero height.
  localparam logic [11:0] PHASE_WIDTH [PHASES] =
    '{12'd0, 12'd4095, 12'd8, 12'd7, 12'd640, 12'd24, 12'd0, 12'd4095};
  localparam logic [11:0] PHASE_HEIGHT [PHASES] =
    '{12'd0, 12'd4095, 12'd32, 12'd4095, 12'd15, 12'd48, 12'd100, 12'd0};

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] code;
    logic [3:0] ridx;
    logic [7:0] rbits;
  } word_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  pix;
    logic [23:0] fg;
    logic [23:0] bg;
    logic        last;
  } cmd_t;

  // A directed row; a pinned row carries its expectation in the row itself.
  typedef struct packed {
    word_t w;
    logic  pinned;
    logic  pinned_clear;
  } probe_t;

  // Clock, reset and block inputs, all known from time zero.
  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [23:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tready = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;

  logic        s_tready;
  logic        m_tvalid;
  logic [79:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic [31:0] prdata;
  logic        pready;

  always #5 clk = ~clk;

  bitmap_text_console #(
    .GLYPH_HEIGHT(GLYPH_ROWS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Console state as the predictor sees it.
  logic [11:0] scr_width  = '0;
  logic [11:0] scr_height = '0;
  logic [23:0] fore_rgb   = 24'hFFFFFF;
  logic [23:0] back_rgb   = 24'h000000;
  logic [8:0]  cur_col    = '0;
  logic [8:0]  cur_line   = '0;
  logic [7:0]  glyph_rows [STORE_DEPTH];
  logic [15:0] rows_loaded [GLYPH_CODES];

  // Glyph being filled in row by row by the random stream.
  logic [7:0]  build_code = 8'h42;
  logic [3:0]  build_row  = '0;

  cmd_t step_cmds[$];
  cmd_t expected_cmds[$];

  bit src_idles     = 1'b1;
  bit sink_idles    = 1'b1;
  bit hold_off_req  = 1'b0;
  int mismatches    = 0;
  int words_sent    = 0;
  int cmds_checked  = 0;
  int clears_seen   = 0;
  int regs_written  = 0;
  int hold_offs     = 0;
  int quiet_cycles  = 0;

  initial begin
    foreach (rows_loaded[i]) rows_loaded[i] = '0;
    foreach (glyph_rows[i]) glyph_rows[i] = '0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void push_clear();
    step_cmds.push_back('{kind: KIND_CLEAR, x: '0, y: '0, pix: '0, fg: '0,
                          bg: back_rgb, last: 1'b1});
    cur_col  = '0;
    cur_line = '0;
  endfunction

  function automatic void start_line(input logic [8:0] lines);
    cur_col  = '0;
    cur_line = cur_line + 9'd1;
    if (cur_line >= lines) push_clear();
  endfunction

  // Work out the command words one input word causes, into step_cmds.
  function automatic void console_step(input word_t w);
    logic [8:0] cols;
    logic [8:0] lines;
    logic [7:0] ch;
    int         n;
    cmd_t       c;
    step_cmds.delete();
    if (scr_width == '0 || scr_height == '0) begin
      cols  = DEFAULT_COLS;
      lines = DEFAULT_LINES;
    end else begin
      cols  = scr_width[11:3];
      lines = {1'b0, scr_height[11:4]};
    end
    case (w.op)
      OP_FONT: begin
        glyph_rows[{w.code, w.ridx}] = w.rbits;
        rows_loaded[w.code][w.ridx] = 1'b1;
      end
      OP_CLEAR: push_clear();
      OP_PRINT: begin
        ch = w.code;
        if (ch == CHAR_LF) begin
          start_line(lines);
        end else if (ch == CHAR_CR) begin
          cur_col = '0;
        end else begin
          if (ch < CHAR_FIRST || ch > CHAR_LAST) ch = CHAR_SUBST;
          for (int r = 0; r < GLYPH_ROWS; r++) begin
            c.kind = KIND_DRAW;
            c.x    = 12'(cur_col) << 3;
            c.y    = (12'(cur_line) << 4) + 12'(r);
            c.pix  = glyph_rows[{ch, 4'(r)}];
            c.fg   = fore_rgb;
            c.bg   = back_rgb;
            c.last = 1'b0;
            step_cmds.push_back(c);
          end
          cur_col = cur_col + 9'd1;
          n = step_cmds.size();
          if (cur_col >= cols) start_line(lines);
          // A clear that follows the glyph already carries the last flag.
          if (step_cmds.size() == n) step_cmds[n - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // ------------------------------------------------------------ stimulus help

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic probe_t probe(input logic [1:0] op, input logic [7:0] code,
                                   input logic [3:0] ridx, input logic [7:0] rbits,
                                   input logic pinned, input logic pinned_clear);
    probe_t p;
    p.w = '{op: op, code: code, ridx: ridx, rbits: rbits};
    p.pinned = pinned;
    p.pinned_clear = pinned_clear;
    return p;
  endfunction

  // Random word, weighted toward font loads followed by printing. Prints only
  // use glyphs whose sixteen rows are all loaded.
  function automatic word_t random_word();
    word_t      w;
    logic [7:0] cand;
    int         pick;
    w.op    = OP_PRINT;
    w.code  = 8'($urandom);
    w.ridx  = 4'($urandom);
    w.rbits = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      w.op   = OP_FONT;
      w.code = build_code;
      w.ridx = build_row;
      build_row = build_row + 4'd1;
      if (build_row == '0) build_code = 8'($urandom_range(32, 126));
    end else if (pick < 24) begin
      w.op = OP_FONT;
    end else if (pick < 36) begin
      w.code = CHAR_LF;
    end else if (pick < 42) begin
      w.code = CHAR_CR;
    end else if (pick < 47) begin
      w.op = OP_CLEAR;
    end else if (pick < 51) begin
      w.op = OP_UNUSED;
    end else if (pick < 63) begin
      // Unprintable byte, drawn with the substitute glyph.
      while (w.code == CHAR_LF || w.code == CHAR_CR ||
             (w.code >= CHAR_FIRST && w.code <= CHAR_LAST))
        w.code = 8'($urandom);
    end else begin
      w.code = CHAR_SUBST;
      repeat (8) begin
        cand = 8'($urandom_range(32, 126));
        if (&rows_loaded[cand]) begin
          w.code = cand;
          break;
        end
      end
    end
    return w;
  endfunction

  // Offer one input word, wait for it to be taken, then predict its results.
  task automatic send_word(input probe_t p);
    int gap;
    gap = src_idles ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, p.w.rbits, p.w.ridx, p.w.code};
    s_tuser  <= p.w.op;
    do @(posedge clk); while (!s_tready);
    words_sent++;
    console_step(p.w);
    if (p.pinned) begin
      if (p.pinned_clear)
        expected_cmds.push_back('{kind: KIND_CLEAR, x: '0, y: '0, pix: '0, fg: '0,
                                  bg: RESET_BACK, last: 1'b1});
    end else begin
      foreach (step_cmds[i]) expected_cmds.push_back(step_cmds[i]);
    end
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [23:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    regs_written++;
    case (index)
      REG_WIDTH:  scr_width  = value[11:0];
      REG_HEIGHT: scr_height = value[11:0];
      REG_FORE:   fore_rgb   = value;
      default:    back_rgb   = value;
    endcase
  endtask

  // Stop offering, let every expected word arrive, then let the block settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  // ----------------------------------------------------------- output side

  // Ready toggles at random; on request it holds off for a long stretch.
  initial begin : sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        hold_offs++;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (sink_idles) stall_left = pick_gap();
      end
    end
  end

  // Check each accepted command word against the oldest expectation.
  always @(posedge clk) begin : check_cmds
    cmd_t got;
    cmd_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{kind: m_tuser, x: m_tdata[11:0], y: m_tdata[23:12],
              pix: m_tdata[31:24], fg: m_tdata[55:32], bg: m_tdata[79:56],
              last: m_tlast};
      if (expected_cmds.size() == 0) begin
        report_mismatch("word with nothing expected, pixel_x", 32'(got.x), '0);
      end else begin
        want = expected_cmds.pop_front();
        cmds_checked++;
        if (want.kind == KIND_CLEAR) clears_seen++;
        if (got.kind !== want.kind)
          report_mismatch("command_kind", 32'(got.kind), 32'(want.kind));
        if (got.x !== want.x)       report_mismatch("pixel_x", 32'(got.x), 32'(want.x));
        if (got.y !== want.y)       report_mismatch("pixel_y", 32'(got.y), 32'(want.y));
        if (got.pix !== want.pix)
          report_mismatch("row_pixels", 32'(got.pix), 32'(want.pix));
        if (got.fg !== want.fg)
          report_mismatch("fore_color", 32'(got.fg), 32'(want.fg));
        if (got.bg !== want.bg)
          report_mismatch("back_color", 32'(got.bg), 32'(want.bg));
        if (got.last !== want.last)
          report_mismatch("last", 32'(got.last), 32'(want.last));
      end
    end
  end

  // Watchdog: too long with no word moving on any port ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pwrite && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // ------------------------------------------------------------ main sequence

  initial begin : stimulus
    probe_t     probes[$];
    logic [7:0] preload_codes [4];
    logic [23:0] fg;
    logic [23:0] bg;
    preload_codes = '{CHAR_SUBST, CHAR_FIRST, CHAR_LAST, CHAR_A};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Load a handful of complete glyphs, the substitute glyph among them.
    foreach (preload_codes[i])
      for (int r = 0; r < GLYPH_ROWS; r++)
        send_word(probe(OP_FONT, preload_codes[i], 4'(r), 8'($urandom), 1'b0, 1'b0));

    // Directed words with the reset registers still in place.
    probes.push_back(probe(OP_CLEAR,  8'h00,      4'h0, 8'h00, 1'b1, 1'b1));
    probes.push_back(probe(OP_UNUSED, 8'hFF,      4'hF, 8'hFF, 1'b1, 1'b0));
    probes.push_back(probe(OP_PRINT,  CHAR_CR,    4'h0, 8'h00, 1'b1, 1'b0));
    probes.push_back(probe(OP_FONT,   CHAR_SUBST, 4'h0, 8'h00, 1'b1, 1'b0));
    probes.push_back(probe(OP_FONT,   CHAR_SUBST, 4'hF, 8'hFF, 1'b1, 1'b0));
    probes.push_back(probe(OP_FONT,   8'hFF,      4'hF, 8'hFF, 1'b1, 1'b0));
    probes.push_back(probe(OP_FONT,   8'h00,      4'h0, 8'h00, 1'b1, 1'b0));
    probes.push_back(probe(OP_PRINT,  CHAR_FIRST, 4'h0, 8'h00, 1'b0, 1'b0));
    probes.push_back(probe(OP_PRINT,  CHAR_LAST,  4'h0, 8'h00, 1'b0, 1'b0));
    probes.push_back(probe(OP_PRINT,  CHAR_A,     4'h0, 8'h00, 1'b0, 1'b0));
    probes.push_back(probe(OP_PRINT,  CHAR_SUBST, 4'h0, 8'h00, 1'b0, 1'b0));
    probes.push_back(probe(OP_PRINT,  8'h00,      4'h0, 8'h00, 1'b0, 1'b0));
    probes.push_back(probe(OP_PRINT,  8'd31,      4'h0, 8'h00, 1'b0, 1'b0));
    probes.push_back(probe(OP_PRINT,  8'd127,     4'h0, 8'h00, 1'b0, 1'b0));
    probes.push_back(probe(OP_PRINT,  8'hFF,      4'hF, 8'hFF, 1'b0, 1'b0));
    probes.push_back(probe(OP_PRINT,  8'h09,      4'h0, 8'h00, 1'b0, 1'b0));
    probes.push_back(probe(OP_PRINT,  CHAR_LF,    4'h0, 8'h00, 1'b0, 1'b0));
    probes.push_back(probe(OP_PRINT,  CHAR_CR,    4'h0, 8'h00, 1'b0, 1'b0));
    probes.push_back(probe(OP_PRINT,  CHAR_A,     4'h0, 8'h00, 1'b0, 1'b0));
    probes.push_back(probe(OP_CLEAR,  8'hFF,      4'hF, 8'hFF, 1'b0, 1'b0));
    probes.push_back(probe(OP_UNUSED, 8'h00,      4'h0, 8'h00, 1'b1, 1'b0));
    foreach (probes[i]) send_word(probes[i]);

    // Random words under a series of screen sizes and colors.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      fg = (ph == 0) ? 24'hFFFFFF : (ph == 1) ? 24'h000000 : 24'($urandom);
      bg = (ph == 0) ? 24'h000000 : (ph == 1) ? 24'hFFFFFF : 24'($urandom);
      write_reg(REG_WIDTH, 24'(PHASE_WIDTH[ph]));
      write_reg(REG_HEIGHT, 24'(PHASE_HEIGHT[ph]));
      write_reg(REG_FORE, fg);
      write_reg(REG_BACK, bg);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      src_idles  = (ph % 3) != 2;
      sink_idles = (ph % 4) != 3;
      // On the large screen, the output stalls while input keeps coming.
      if (ph == 1) begin
        src_idles    = 1'b0;
        hold_off_req = 1'b1;
      end
      repeat (WORDS_PER_PHASE) send_word('{w: random_word(), pinned: 1'b0,
                                           pinned_clear: 1'b0});
    end

    wait_idle();
    $display("Sent %0d input words and checked %0d command words, %0d of them clears.",
             words_sent, cmds_checked, clears_seen);
    $display("Made %0d register writes over %0d screen settings, %0d long output stall(s).",
             regs_written, PHASES, hold_offs);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule
